@@ sv/fri_pkg.sv @@
// Shared constants, payload types and codes of the fuzzy rule inference core.
package fri_pkg;

  // Table dimensions
  localparam int MAX_VARS    = 16;
  localparam int MAX_RULES   = 32;
  localparam int MAX_LABELS  = 8;
  localparam int MAX_OUTPUTS = 8;

  localparam int VAR_W  = $clog2(MAX_VARS);
  localparam int RULE_W = $clog2(MAX_RULES);
  localparam int LAB_W  = $clog2(MAX_LABELS);
  localparam int OUT_W  = $clog2(MAX_OUTPUTS);

  // Arithmetic widths: activation Q1.15, sums over all rules plus default
  localparam int ACT_W = 16;
  localparam int SUM_W = 21;
  localparam int FRAC  = 15;
  localparam int DVD_W = SUM_W + FRAC;
  localparam int CNT_W = $clog2(DVD_W);

  localparam logic [ACT_W-1:0] ONE_Q15 = 16'h8000;

  // Input word opcodes
  typedef enum logic [1:0] {
    OP_BREAK = 2'd0,
    OP_ANTE  = 2'd1,
    OP_CONS  = 2'd2,
    OP_OBS   = 2'd3
  } opcode_t;

  // Configuration register indexes
  localparam logic [2:0] REG_VAR_COUNT  = 3'd0;
  localparam logic [2:0] REG_RULE_COUNT = 3'd1;
  localparam logic [2:0] REG_LABEL_COUNT = 3'd2;
  localparam logic [2:0] REG_CONS_COUNT = 3'd3;
  localparam logic [2:0] REG_DONT_CARE  = 3'd4;
  localparam logic [2:0] REG_DEFAULT    = 3'd5;

  typedef struct packed {
    opcode_t            opcode;
    logic [4:0]         row_index;
    logic [3:0]         col_index;
    logic signed [15:0] value;
  } in_t;

  typedef struct packed {
    logic [2:0]  output_index;
    logic [15:0] prediction;
    logic        last;
  } out_t;

endpackage

@@ sv/fuzzy_rule_inference_core.sv @@
// Top level: table loading, observation buffering and shared-divider rule evaluation.
//
// Words with opcodes 0..2 load tables and the core stays ready. An
// observation word for the last variable starts an evaluation and busy stays
// high until the last prediction has been strobed out. An evaluation scans
// the breakpoints of each variable, divides once for each variable whose
// value falls between breakpoints, walks the rules, adds the default rule and
// divides once per output. The single-ported breakpoint and antecedent
// memories and the one 36-step restoring divider set the pace of these steps.
// Predictions come out one per strobe with no flow control: the receiver must
// take each word in the cycle that valid is high.
module fuzzy_rule_inference_core
  import fri_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  in_t        in_word,
  output logic       busy,
  output logic       valid,
  output out_t       out_word,
  input  logic       cfg_write,
  input  logic [2:0] cfg_addr,
  input  logic [7:0] cfg_data
);

  typedef enum logic [3:0] {
    IDLE, BP_RD, BP_CMP, VAR_END, VAR_DIV, ANT_RD, ANT_ACC, DFLT, OUT_START, OUT_DIV
  } state_t;

  state_t state;

  // Configuration registers
  logic [4:0] var_count;
  logic [5:0] rule_count;
  logic [3:0] label_count;
  logic [3:0] consequent_count;
  logic [3:0] dont_care_label;
  logic [7:0] default_consequents;

  always_ff @(posedge clk) begin
    if (rst) begin
      var_count           <= 5'd1;
      rule_count          <= 6'd0;
      label_count         <= 4'd1;
      consequent_count    <= 4'd1;
      dont_care_label     <= 4'd1;
      default_consequents <= 8'd0;
    end else if (cfg_write) begin
      case (cfg_addr)
        REG_VAR_COUNT:   var_count           <= cfg_data[4:0];
        REG_RULE_COUNT:  rule_count          <= cfg_data[5:0];
        REG_LABEL_COUNT: label_count         <= cfg_data[3:0];
        REG_CONS_COUNT:  consequent_count    <= cfg_data[3:0];
        REG_DONT_CARE:   dont_care_label     <= cfg_data[3:0];
        REG_DEFAULT:     default_consequents <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective counts
  logic [4:0] nv;
  logic [5:0] nr;
  logic [3:0] nlab;
  logic [3:0] nout;

  always_comb begin
    nv   = (var_count == 5'd0) ? 5'd1 : (var_count > 5'(MAX_VARS)) ? 5'(MAX_VARS) : var_count;
    nr   = (rule_count > 6'(MAX_RULES)) ? 6'(MAX_RULES) : rule_count;
    nlab = (label_count == 4'd0) ? 4'd1
         : (label_count > 4'(MAX_LABELS)) ? 4'(MAX_LABELS) : label_count;
    nout = (consequent_count == 4'd0) ? 4'd1
         : (consequent_count > 4'(MAX_OUTPUTS)) ? 4'(MAX_OUTPUTS) : consequent_count;
  end

  logic accept;
  assign accept = start && (state == IDLE);
  assign busy   = (state != IDLE);

  // Sequencer counters
  logic [VAR_W-1:0]  v_idx;
  logic [LAB_W-1:0]  i_idx;
  logic [RULE_W-1:0] r_idx;
  logic [OUT_W-1:0]  j_idx;

  logic last_var, last_lab, last_rule, last_out;
  assign last_var  = ({1'b0, v_idx} == 5'(nv - 5'd1));
  assign last_lab  = ({1'b0, i_idx} == (nlab - 4'd1));
  assign last_rule = ({1'b0, r_idx} == (nr - 6'd1));
  assign last_out  = ({1'b0, j_idx} == (nout - 4'd1));

  // Breakpoint memory
  logic signed [15:0] bp_mem [MAX_VARS*MAX_LABELS];
  logic signed [15:0] bp_rdata;

  always_ff @(posedge clk) begin
    if (accept && in_word.opcode == OP_BREAK && in_word.row_index < 5'(MAX_VARS)
        && in_word.col_index < 4'(MAX_LABELS)) begin
      bp_mem[{in_word.row_index[VAR_W-1:0], in_word.col_index[LAB_W-1:0]}] <= in_word.value;
    end
    bp_rdata <= bp_mem[{v_idx, i_idx}];
  end

  // Antecedent memory
  logic [3:0] ant_mem [MAX_RULES*MAX_VARS];
  logic [3:0] ant_rdata;

  always_ff @(posedge clk) begin
    if (accept && in_word.opcode == OP_ANTE) begin
      ant_mem[{in_word.row_index, in_word.col_index}] <= in_word.value[3:0];
    end
    ant_rdata <= ant_mem[{r_idx, v_idx}];
  end

  // Consequent masks and observation buffer
  logic [7:0]         cons_tab [MAX_RULES];
  logic signed [15:0] obs [MAX_VARS];

  always_ff @(posedge clk) begin
    if (accept && in_word.opcode == OP_CONS) begin
      cons_tab[in_word.row_index] <= in_word.value[7:0];
    end
    if (accept && in_word.opcode == OP_OBS) begin
      obs[in_word.col_index] <= in_word.value;
    end
  end

  // Per-variable interpolation summary
  logic [3:0]       vi_cnt  [MAX_VARS];
  logic             vi_full [MAX_VARS];
  logic [ACT_W-1:0] vi_t    [MAX_VARS];

  // Scan accumulators
  logic [3:0]         cnt_lt, cnt_le;
  logic signed [15:0] max_lt, min_ge;

  // Rule accumulators
  logic [ACT_W-1:0] act, mx;
  logic             all_dc;
  logic [SUM_W-1:0] den;
  logic [SUM_W-1:0] num [MAX_OUTPUTS];

  // Shared restoring divider
  logic [SUM_W-1:0] div_rem, div_den;
  logic [DVD_W-1:0] div_q;
  logic [CNT_W-1:0] div_cnt;
  logic [SUM_W:0]   rem_sh;
  logic             div_ge;
  logic [SUM_W-1:0] rem_step;
  logic [DVD_W-1:0] q_step;
  logic             div_last;

  always_comb begin
    rem_sh   = {div_rem, div_q[DVD_W-1]};
    div_ge   = rem_sh >= {1'b0, div_den};
    rem_step = div_ge ? SUM_W'(rem_sh - {1'b0, div_den}) : rem_sh[SUM_W-1:0];
    q_step   = {div_q[DVD_W-2:0], div_ge};
    div_last = (div_cnt == CNT_W'(DVD_W - 1));
  end

  // Scan compare of one breakpoint against the observation
  logic signed [15:0] x_cur;
  logic               b_lt, b_le, interior;
  logic [15:0]        dx, dd;

  always_comb begin
    x_cur    = obs[v_idx];
    b_lt     = bp_rdata < x_cur;
    b_le     = bp_rdata <= x_cur;
    interior = (cnt_lt != 4'd0) && (cnt_le != nlab);
    dx       = 16'(17'(x_cur) - 17'(max_lt));
    dd       = 16'(17'(min_ge) - 17'(max_lt));
  end

  // Membership of the current rule's label for the current variable
  logic [3:0]       lab, lo_pos;
  logic             all_one, lab_ok, y_lo, y_hi, y_first, y_end;
  logic [ACT_W-1:0] memb, act_new, a_rule;
  logic             dc_new;

  always_comb begin
    lab     = ant_rdata;
    all_one = (lab == dont_care_label) || (lab == nlab);
    lab_ok  = lab < nlab;
    lo_pos  = vi_cnt[v_idx] - 4'd1;
    y_first = all_one || (lab_ok && lab == 4'd0);
    y_end   = all_one || (lab_ok && lab == (nlab - 4'd1));
    y_lo    = all_one || (lab_ok && lab == lo_pos);
    y_hi    = all_one || (lab_ok && lab == vi_cnt[v_idx]);
    if (vi_cnt[v_idx] == 4'd0) begin
      memb = y_first ? ONE_Q15 : '0;
    end else if (vi_full[v_idx]) begin
      memb = y_end ? ONE_Q15 : '0;
    end else if (y_lo == y_hi) begin
      memb = y_lo ? ONE_Q15 : '0;
    end else if (y_hi) begin
      memb = vi_t[v_idx];
    end else begin
      memb = ONE_Q15 - vi_t[v_idx];
    end
    act_new = (memb < act) ? memb : act;
    dc_new  = all_dc && (lab == dont_care_label);
    a_rule  = dc_new ? '0 : act_new;
  end

  logic [ACT_W-1:0] dflt_act;
  assign dflt_act = ONE_Q15 - mx;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        IDLE: begin
          if (accept && in_word.opcode == OP_OBS
              && {1'b0, in_word.col_index} == 5'(nv - 5'd1)) begin
            v_idx  <= '0;
            i_idx  <= '0;
            cnt_lt <= '0;
            cnt_le <= '0;
            max_lt <= 16'sh8000;
            min_ge <= 16'sh7fff;
            mx     <= '0;
            den    <= '0;
            for (int k = 0; k < MAX_OUTPUTS; k++) num[k] <= '0;
            state  <= BP_RD;
          end
        end
        BP_RD: state <= BP_CMP;
        BP_CMP: begin
          cnt_lt <= cnt_lt + {3'd0, b_lt};
          cnt_le <= cnt_le + {3'd0, b_le};
          if (b_lt && bp_rdata > max_lt) max_lt <= bp_rdata;
          if (!b_lt && bp_rdata < min_ge) min_ge <= bp_rdata;
          if (last_lab) begin
            state <= VAR_END;
          end else begin
            i_idx <= i_idx + 1'b1;
            state <= BP_RD;
          end
        end
        VAR_END, VAR_DIV: begin
          if (state == VAR_END && interior) begin
            div_q   <= DVD_W'({dx, 15'd0});
            div_rem <= '0;
            div_den <= SUM_W'(dd);
            div_cnt <= '0;
            state   <= VAR_DIV;
          end else if (state == VAR_DIV && !div_last) begin
            div_q   <= q_step;
            div_rem <= rem_step;
            div_cnt <= div_cnt + 1'b1;
          end else begin
            vi_cnt[v_idx]  <= cnt_lt;
            vi_full[v_idx] <= (cnt_le == nlab);
            vi_t[v_idx]    <= (state == VAR_DIV) ? q_step[ACT_W-1:0] : '0;
            cnt_lt <= '0;
            cnt_le <= '0;
            max_lt <= 16'sh8000;
            min_ge <= 16'sh7fff;
            i_idx  <= '0;
            if (last_var) begin
              v_idx  <= '0;
              r_idx  <= '0;
              act    <= ONE_Q15;
              all_dc <= 1'b1;
              state  <= (nr == 6'd0) ? DFLT : ANT_RD;
            end else begin
              v_idx <= v_idx + 1'b1;
              state <= BP_RD;
            end
          end
        end
        ANT_RD: state <= ANT_ACC;
        ANT_ACC: begin
          if (last_var) begin
            if (a_rule > mx) mx <= a_rule;
            den <= den + SUM_W'(a_rule);
            for (int k = 0; k < MAX_OUTPUTS; k++) begin
              if (cons_tab[r_idx][k]) num[k] <= num[k] + SUM_W'(a_rule);
            end
            v_idx  <= '0;
            act    <= ONE_Q15;
            all_dc <= 1'b1;
            if (last_rule) begin
              state <= DFLT;
            end else begin
              r_idx <= r_idx + 1'b1;
              state <= ANT_RD;
            end
          end else begin
            act    <= act_new;
            all_dc <= dc_new;
            v_idx  <= v_idx + 1'b1;
            state  <= ANT_RD;
          end
        end
        DFLT: begin
          den <= den + SUM_W'(dflt_act);
          for (int k = 0; k < MAX_OUTPUTS; k++) begin
            if (default_consequents[k]) num[k] <= num[k] + SUM_W'(dflt_act);
          end
          j_idx <= '0;
          state <= OUT_START;
        end
        OUT_START: begin
          div_q   <= {num[j_idx], 15'd0};
          div_rem <= '0;
          div_den <= den;
          div_cnt <= '0;
          state   <= OUT_DIV;
        end
        OUT_DIV: begin
          if (!div_last) begin
            div_q   <= q_step;
            div_rem <= rem_step;
            div_cnt <= div_cnt + 1'b1;
          end else begin
            valid                 <= 1'b1;
            out_word.output_index <= j_idx;
            out_word.prediction   <= q_step[ACT_W-1:0];
            out_word.last         <= last_out;
            if (last_out) begin
              state <= IDLE;
            end else begin
              j_idx <= j_idx + 1'b1;
              state <= OUT_START;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Checks
  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    valid && !out_word.last |-> busy)
    else $error("core went idle before the last prediction");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    valid && out_word.last |=> !valid)
    else $error("activity after the last prediction");

  a_pred_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> out_word.prediction <= ONE_Q15)
    else $error("prediction above one");

  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    start && !busy && in_word.opcode != OP_OBS |=> !busy)
    else $error("table load made the core busy");

  a_den_floor: assert property (@(posedge clk) disable iff (rst)
    state == OUT_START |-> den >= SUM_W'(ONE_Q15))
    else $error("averaging denominator below one");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the fuzzy rule inference core.
`timescale 1ns / 1ps

module testbench;
  import fri_pkg::*;

  localparam int LIMIT = 5000000;
  localparam int SETTLE = 60;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_t in_word = '0;
  logic busy;
  logic valid;
  out_t out_word;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_addr = '0;
  logic [7:0] cfg_data = '0;

  fuzzy_rule_inference_core i_dut (
    .clk(clk), .rst(rst), .start(start), .in_word(in_word), .busy(busy),
    .valid(valid), .out_word(out_word), .cfg_write(cfg_write),
    .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  // Clock, 8 ns period
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Shadow state of the core
  int bp_mem [MAX_VARS*MAX_LABELS];
  int unsigned ante_mem [MAX_RULES*MAX_VARS];
  int unsigned cons_mem [MAX_RULES];
  int obs_mem [MAX_VARS];
  int unsigned n_vars_r = 1, n_rules_r = 0, n_labels_r = 1, n_outs_r = 1;
  int unsigned dont_care_r = 1, default_mask_r = 0;

  in_t word_q[$];
  out_t prediction_q[$];
  int errors = 0;
  int idle_pct = 0;
  int cycles = 0;

  function automatic void queue_word(in_t w);
    word_q = {word_q, w};
  endfunction

  function automatic int unsigned eff_vars();
    return n_vars_r < 1 ? 1 : (n_vars_r > MAX_VARS ? MAX_VARS : n_vars_r);
  endfunction

  function automatic int unsigned eff_labels();
    return n_labels_r < 1 ? 1 : (n_labels_r > MAX_LABELS ? MAX_LABELS : n_labels_r);
  endfunction

  // Piecewise-linear membership grade in Q1.15
  function automatic int unsigned grade(int vi, int unsigned lab, int x);
    int xs[MAX_LABELS];
    int unsigned ys[MAX_LABELS];
    int n, i, j, k, lo, v;
    bit all_one;
    longint t;
    n = eff_labels();
    all_one = (lab == dont_care_r) || (lab == n);
    for (i = 0; i < n; i++) begin
      v = bp_mem[vi*MAX_LABELS + i];
      for (j = i; j > 0 && xs[j-1] > v; j--) xs[j] = xs[j-1];
      xs[j] = v;
    end
    for (i = 0; i < n; i++)
      ys[i] = (all_one || (lab < n && i == lab)) ? 32768 : 0;
    if (x <= xs[0]) return ys[0];
    if (x >= xs[n-1]) return ys[n-1];
    for (k = 1; k < n && xs[k] < x; k++) ;
    if (k >= n) k = n - 1;
    lo = k - 1;
    if (xs[k] == xs[lo] || ys[k] == ys[lo]) return ys[lo];
    t = (longint'(x - xs[lo]) * 32768) / longint'(xs[k] - xs[lo]);
    return ys[k] > ys[lo] ? int'(t) : 32768 - int'(t);
  endfunction

  // Rule activations, default rule and one weighted average per consequent
  function automatic void infer_outputs();
    int unsigned acts[MAX_RULES];
    int unsigned nv, nr, no, r, v, j, mx, act, m, dflt_act;
    longint den, num;
    bit all_dc;
    out_t res;
    nv = eff_vars();
    nr = n_rules_r > MAX_RULES ? MAX_RULES : n_rules_r;
    no = n_outs_r < 1 ? 1 : (n_outs_r > 8 ? 8 : n_outs_r);
    mx = 0;
    den = 0;
    for (r = 0; r < nr; r++) begin
      all_dc = 1'b1;
      act = 32768;
      for (v = 0; v < nv; v++)
        if (ante_mem[r*MAX_VARS + v] != dont_care_r) all_dc = 1'b0;
      if (!all_dc)
        for (v = 0; v < nv; v++) begin
          m = grade(v, ante_mem[r*MAX_VARS + v], obs_mem[v]);
          if (m < act) act = m;
        end
      acts[r] = all_dc ? 0 : act;
      if (acts[r] > mx) mx = acts[r];
      den += acts[r];
    end
    dflt_act = 32768 - mx;
    den += dflt_act;
    for (j = 0; j < no; j++) begin
      num = 0;
      for (r = 0; r < nr; r++)
        if (cons_mem[r][j]) num += acts[r];
      if (default_mask_r[j]) num += dflt_act;
      res.output_index = j[2:0];
      res.prediction = 16'((num * 32768) / den);
      res.last = (j == no - 1);
      prediction_q = {prediction_q, res};
    end
  endfunction

  // Apply one accepted word to the shadow state
  function automatic void apply_word(in_t w);
    int row, col;
    row = w.row_index;
    col = w.col_index;
    case (w.opcode)
      OP_BREAK: if (row < MAX_VARS && col < MAX_LABELS)
        bp_mem[row*MAX_LABELS + col] = w.value;
      OP_ANTE: if (row < MAX_RULES && col < MAX_VARS)
        ante_mem[row*MAX_VARS + col] = w.value[3:0];
      OP_CONS: if (row < MAX_RULES) cons_mem[row] = w.value[7:0];
      default: begin
        if (col < MAX_VARS) obs_mem[col] = w.value;
        if (col == eff_vars() - 1) infer_outputs();
      end
    endcase
  endfunction

  function automatic in_t mk(opcode_t op, int row, int col, int val);
    in_t w;
    w.opcode = op;
    w.row_index = row[4:0];
    w.col_index = col[3:0];
    w.value = val[15:0];
    return w;
  endfunction

  // Fixed-point sample: mostly near zero so breakpoints collide and bracket it
  function automatic int rand_point();
    if ($urandom_range(2) == 0) return int'($urandom_range(65535)) - 32768;
    return int'($urandom_range(512)) - 256;
  endfunction

  // Driver: one word presented at a time, held while busy
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) apply_word(in_word);
      if (!start || !busy) begin
        if (word_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_word <= word_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: each strobed word against the oldest pending prediction
  always @(posedge clk) begin
    out_t exp_w;
    if (!rst && valid) begin
      if (prediction_q.size() == 0) begin
        $display("%0t: unexpected word, actual %p", $time, out_word);
        errors++;
      end else begin
        exp_w = prediction_q.pop_front();
        if (out_word.output_index !== exp_w.output_index) begin
          $display("%0t: output_index expected %0d actual %0d", $time,
                   exp_w.output_index, out_word.output_index);
          errors++;
        end
        if (out_word.prediction !== exp_w.prediction) begin
          $display("%0t: prediction expected %0d actual %0d", $time,
                   exp_w.prediction, out_word.prediction);
          errors++;
        end
        if (out_word.last !== exp_w.last) begin
          $display("%0t: last expected %0d actual %0d", $time,
                   exp_w.last, out_word.last);
          errors++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("fuzzy_rule_inference_core regression: fail");
      $finish;
    end
  end

  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (word_q.size() > 0 || start || busy || prediction_q.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] a, int unsigned d);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_addr <= a;
    cfg_data <= d[7:0];
    case (a)
      REG_VAR_COUNT: n_vars_r = d & 8'h1F;
      REG_RULE_COUNT: n_rules_r = d & 8'h3F;
      REG_LABEL_COUNT: n_labels_r = d & 8'hF;
      REG_CONS_COUNT: n_outs_r = d & 8'hF;
      REG_DONT_CARE: dont_care_r = d & 8'hF;
      default: default_mask_r = d & 8'hFF;
    endcase
  endtask

  task automatic set_all(int unsigned vc, rc, lc, cc, dc, dm);
    reg_write(REG_VAR_COUNT, vc);
    reg_write(REG_RULE_COUNT, rc);
    reg_write(REG_LABEL_COUNT, lc);
    reg_write(REG_CONS_COUNT, cc);
    reg_write(REG_DONT_CARE, dc);
    reg_write(REG_DEFAULT, dm);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Complete observation: every variable in use, trigger last
  task automatic push_observation();
    int nv;
    nv = eff_vars();
    for (int v = 0; v < nv; v++) queue_word(mk(OP_OBS, $urandom, v, rand_point()));
  endtask

  task automatic random_words(int count);
    int sent, pick, lab;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(9);
      if (pick < 2) begin
        queue_word(mk(OP_BREAK, $urandom, $urandom, rand_point()));
        sent++;
      end else if (pick == 2) begin
        lab = $urandom_range(2) == 0 ? int'(dont_care_r) : int'($urandom_range(15));
        queue_word(mk(OP_ANTE, $urandom, $urandom, ($urandom & 32'hFFF0) | lab));
        sent++;
      end else if (pick == 3) begin
        queue_word(mk(OP_CONS, $urandom, $urandom, $urandom));
        sent++;
      end else if (pick == 4) begin
        queue_word(mk(OP_OBS, $urandom, $urandom, rand_point()));
        sent++;
      end else begin
        push_observation();
        sent += eff_vars();
      end
    end
  endtask

  initial begin
    int pcts[3] = '{0, 80, 38};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Fill every table entry that the settings below read
    for (int v = 0; v < MAX_VARS; v++)
      for (int s = 0; s < (v < 4 ? MAX_LABELS : 3); s++)
        queue_word(mk(OP_BREAK, v, s, rand_point()));
    for (int r = 0; r < MAX_RULES; r++)
      for (int c = 0; c < (r < 2 ? MAX_VARS : (r < 10 ? 4 : 1)); c++)
        queue_word(mk(OP_ANTE, r, c, $urandom));
    for (int i = 0; i < MAX_RULES; i++)
      queue_word(mk(OP_CONS, i, 0, $urandom));
    for (int i = 0; i < MAX_VARS; i++)
      queue_word(mk(OP_OBS, 0, i, rand_point()));
    drain();

    // Directed: extremes, equal breakpoints, skipped rule, all-one and all-zero labels
    set_all(2, 3, 3, 3, 5, 8'b101);
    queue_word(mk(OP_BREAK, 0, 0, 32767));
    queue_word(mk(OP_BREAK, 0, 1, -32768));
    queue_word(mk(OP_BREAK, 0, 2, 0));
    queue_word(mk(OP_BREAK, 1, 0, 100));
    queue_word(mk(OP_BREAK, 1, 1, 100));
    queue_word(mk(OP_BREAK, 1, 2, 200));
    queue_word(mk(OP_BREAK, 20, 9, 1234));
    queue_word(mk(OP_ANTE, 0, 0, 0));
    queue_word(mk(OP_ANTE, 0, 1, 1));
    queue_word(mk(OP_ANTE, 1, 0, 5));
    queue_word(mk(OP_ANTE, 1, 1, 5));
    queue_word(mk(OP_ANTE, 2, 0, 3));
    queue_word(mk(OP_ANTE, 2, 1, 16'hFFF6));
    queue_word(mk(OP_CONS, 0, 0, 1));
    queue_word(mk(OP_CONS, 1, 0, 2));
    queue_word(mk(OP_CONS, 2, 0, 16'hFF07));
    queue_word(mk(OP_OBS, 0, 0, -32768));
    queue_word(mk(OP_OBS, 0, 1, 50));
    queue_word(mk(OP_OBS, 0, 0, 32767));
    queue_word(mk(OP_OBS, 0, 1, 100));
    queue_word(mk(OP_OBS, 0, 0, -1));
    queue_word(mk(OP_OBS, 0, 1, 150));
    queue_word(mk(OP_OBS, 31, 15, -7));
    queue_word(mk(OP_OBS, 0, 0, 16384));
    queue_word(mk(OP_OBS, 0, 1, 300));
    drain();

    // Random phases over several settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = pcts[ph % 3];
      case (ph)
        0: set_all(2, 3, 3, 2, 3, 8'hA5);
        1: set_all(31, 2, 3, 8, 15, 8'hFF);
        2: set_all(0, 0, 0, 0, 0, 8'h00);
        3: set_all(1, 63, 15, 15, 7, 8'h5A);
        default: set_all($urandom_range(1, 4), $urandom_range(0, 10), $urandom_range(1, 8),
                         $urandom_range(1, 8), $urandom_range(0, 15), $urandom_range(255));
      endcase
      random_words(28);
      drain();
    end

    if (errors == 0) begin
      $display("fuzzy_rule_inference_core regression: pass");
    end else begin
      $display("fuzzy_rule_inference_core regression: fail");
    end
    $finish;
  end

endmodule
